// ===== design/wlbt_pkg.sv =====
package wlbt_pkg;

    // Defaults for the top-level parameters.
    localparam int TILE_SAMPLES_DEF     = 16384;
    localparam int WEIGHT_LAYERS_DEF    = 6;
    localparam int WEIGHT_FRAC_BITS_DEF = 12;

    // Field widths.
    localparam int CMD_W     = 2;
    localparam int OFFSET_W  = 14;
    localparam int SAMPLE_W  = 16;
    localparam int WEIGHT_W  = 16;
    localparam int LAYER_W   = 8;
    localparam int CFG_IDX_W = 3;

    // Arithmetic widths of the weighted mean.
    localparam int SUM_W     = WEIGHT_W + 1;
    localparam int PROD_W    = SAMPLE_W + WEIGHT_W;
    localparam int NUM_W     = PROD_W + 1;
    localparam int QUO_W     = SAMPLE_W;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    // Tag stored beside each sample; a sample is valid when its tag matches
    // the current epoch. Tag zero never matches.
    localparam int EPOCH_W = 8;
    localparam int MEM_W   = EPOCH_W + SAMPLE_W;

    localparam int NUM_WEIGHT_REGS = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_START     = 2'd0,
        CMD_BLEND     = 2'd1,
        CMD_END_LAYER = 2'd2,
        CMD_READ      = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT0    = 3'd0,
        REG_WEIGHT1    = 3'd1,
        REG_WEIGHT2    = 3'd2,
        REG_WEIGHT3    = 3'd3,
        REG_WEIGHT4    = 3'd4,
        REG_WEIGHT5    = 3'd5,
        REG_NULL_VALUE = 3'd6
    } reg_idx_t;

endpackage

// ===== design/wlbt_ram.sv =====
module wlbt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/weighted_layer_blend_tile_top.sv =====
// Weighted layer blend into a tile store of 16-bit unsigned samples.
// Input stream: s_tdata carries the sample offset and the source sample,
// s_tuser carries the command and the null flag of the source. Every
// accepted transfer produces exactly one result transfer on the m_ side:
// the stored sample (the null value when blank, zero for start and
// end-of-layer), the zero weight sum flag and the layer counter.
// Items are handled one at a time. Start and end-of-layer go from idle
// straight to the finish state, reads and blends that need no mean pass
// through an evaluation state, and a blend that forms a weighted mean takes
// one memory read, two passes through a shared 16x16 multiplier, 16 steps of
// a radix-2 divider and a write-back. The divider sets the sustained blend rate.
// The result sits in an output register, so a new item is accepted while
// it waits; if the receiver stalls, the next item holds in its last cycle
// until the output register frees up.
// After reset the block runs a clearing pass over every address of the store,
// with s_tready low; configuration writes are taken throughout.
// A start command only advances an 8-bit tag, so every 255th start is
// followed by the same clearing pass.
module weighted_layer_blend_tile_top #(
    parameter int TILE_SAMPLES     = wlbt_pkg::TILE_SAMPLES_DEF,
    parameter int WEIGHT_LAYERS    = wlbt_pkg::WEIGHT_LAYERS_DEF,
    parameter int WEIGHT_FRAC_BITS = wlbt_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    // sample_offset[13:0], source_sample[29:14], zero fill[31:30]
    input  logic [31:0] s_tdata,
    // command[1:0], source_is_null[2]
    input  logic [2:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // sample_value[15:0], current_layer[23:16]
    output logic [23:0] m_tdata,
    // zero_weight_sum[0]
    output logic [0:0]  m_tuser
);

    localparam int ADDR_W    = $clog2(TILE_SAMPLES);
    localparam int OFF_EXT_W =
        (ADDR_W > wlbt_pkg::OFFSET_W ? ADDR_W : wlbt_pkg::OFFSET_W) + 1;
    localparam int SAMPLE_W  = wlbt_pkg::SAMPLE_W;
    localparam int WEIGHT_W  = wlbt_pkg::WEIGHT_W;
    localparam int LAYER_W   = wlbt_pkg::LAYER_W;
    localparam int SUM_W     = wlbt_pkg::SUM_W;
    localparam int PROD_W    = wlbt_pkg::PROD_W;
    localparam int NUM_W     = wlbt_pkg::NUM_W;
    localparam int QUO_W     = wlbt_pkg::QUO_W;
    localparam int DIV_CNT_W = wlbt_pkg::DIV_CNT_W;
    localparam int EPOCH_W   = wlbt_pkg::EPOCH_W;
    localparam int MEM_W     = wlbt_pkg::MEM_W;
    localparam int CFG_SEL_W = wlbt_pkg::CFG_IDX_W;

    localparam logic [WEIGHT_W-1:0]  WEIGHT_ONE  = WEIGHT_W'(1 << WEIGHT_FRAC_BITS);
    localparam logic [LAYER_W-1:0]   MAX_LAYER   = LAYER_W'(WEIGHT_LAYERS - 1);
    localparam logic [LAYER_W-1:0]   LAYER_FULL  = '1;
    localparam logic [ADDR_W-1:0]    LAST_ADDR   = ADDR_W'(TILE_SAMPLES - 1);
    localparam logic [DIV_CNT_W-1:0] LAST_STEP   = DIV_CNT_W'(QUO_W - 1);
    localparam logic [EPOCH_W-1:0]   EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0]   EPOCH_LAST  = '1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_WB,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    wlbt_pkg::cmd_t         cmd_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic                   in_range_reg;
    logic [SAMPLE_W-1:0]    src_reg;
    logic                   src_null_reg;
    logic [EPOCH_W-1:0]     epoch_reg;
    logic [ADDR_W-1:0]      clr_addr_reg;
    logic                   clear_after_reg;
    logic [WEIGHT_W-1:0]    running_reg;
    logic [LAYER_W-1:0]     layer_reg;
    logic [WEIGHT_W-1:0]    weight_reg [wlbt_pkg::NUM_WEIGHT_REGS];
    logic [SAMPLE_W-1:0]    null_reg;
    logic [WEIGHT_W-1:0]    lw_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SAMPLE_W-1:0]    stored_reg;
    logic [PROD_W-1:0]      acc_reg;
    logic [SUM_W-1:0]       rem_reg;
    logic [QUO_W-1:0]       quo_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [SAMPLE_W-1:0]    res_value_reg;
    logic                   res_flag_reg;
    logic                   m_tvalid_reg;
    logic [SAMPLE_W-1:0]    m_value_reg;
    logic                   m_flag_reg;
    logic [LAYER_W-1:0]     m_layer_reg;

    wlbt_pkg::cmd_t         in_cmd;
    logic [OFF_EXT_W-1:0]   in_off_ext;
    logic                   in_range;
    logic [ADDR_W-1:0]      in_addr;
    logic [SAMPLE_W-1:0]    in_src;
    logic                   in_accept;

    logic [LAYER_W-1:0]     layer_sel;
    logic [WEIGHT_W-1:0]    layer_weight;
    logic [SUM_W-1:0]       weight_sum;
    logic [SUM_W-1:0]       half_sum;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [MEM_W-1:0]       ram_wdata;
    logic [MEM_W-1:0]       ram_rdata;
    logic                   entry_valid;
    logic [SAMPLE_W-1:0]    entry_data;
    logic [SAMPLE_W-1:0]    stored_or_null;
    logic                   blend_active;
    logic                   take_source;

    logic [SAMPLE_W-1:0]    mul_a;
    logic [WEIGHT_W-1:0]    mul_b;
    logic [PROD_W-1:0]      product;
    logic [NUM_W-1:0]       numerator;
    logic [SUM_W:0]         div_shift;
    logic [SUM_W:0]         div_trial;

    // Input decode.
    assign in_cmd     = wlbt_pkg::cmd_t'(s_tuser[1:0]);
    assign in_off_ext = OFF_EXT_W'(s_tdata[wlbt_pkg::OFFSET_W-1:0]);
    assign in_range   = in_off_ext < OFF_EXT_W'(TILE_SAMPLES);
    assign in_addr    = in_off_ext[ADDR_W-1:0];
    assign in_src     = s_tdata[wlbt_pkg::OFFSET_W +: SAMPLE_W];
    assign in_accept  = s_tvalid && s_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_layer_reg, m_value_reg};
    assign m_tuser  = m_flag_reg;

    // Layers past the end of the weight table reuse its last weight.
    assign layer_sel    = (layer_reg > MAX_LAYER) ? MAX_LAYER : layer_reg;
    assign layer_weight = weight_reg[layer_sel[CFG_SEL_W-1:0]];
    assign weight_sum   = {1'b0, running_reg} + {1'b0, layer_weight};
    assign half_sum     = weight_sum >> 1;

    // Entry read back from the store, valid only under the current tag.
    assign entry_valid    = in_range_reg && (ram_rdata[MEM_W-1:SAMPLE_W] == epoch_reg);
    assign entry_data     = ram_rdata[SAMPLE_W-1:0];
    assign stored_or_null = entry_valid ? entry_data : null_reg;
    assign blend_active   = (cmd_reg == wlbt_pkg::CMD_BLEND) && !src_null_reg && in_range_reg;
    assign take_source    = !entry_valid || (entry_data == null_reg) || (sum_reg == '0);

    // One multiplier shared by both products of the weighted mean.
    assign mul_a     = (state_reg == ST_MUL1) ? stored_reg : src_reg;
    assign mul_b     = (state_reg == ST_MUL1) ? running_reg : lw_reg;
    assign product   = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign numerator = NUM_W'(acc_reg) + NUM_W'(product);

    // Restoring divider step; the quotient bits shift in behind the
    // remaining numerator bits in quo_reg.
    assign div_shift = {rem_reg, quo_reg[QUO_W-1]};
    assign div_trial = div_shift - {1'b0, sum_reg};

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = {epoch_reg, src_reg};
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_EVAL: begin
                ram_we = blend_active && take_source;
            end
            ST_WB: begin
                ram_we    = 1'b1;
                ram_wdata = {epoch_reg, quo_reg};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    wlbt_ram #(
        .WIDTH (MEM_W),
        .DEPTH (TILE_SAMPLES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            epoch_reg       <= EPOCH_FIRST;
            clr_addr_reg    <= '0;
            clear_after_reg <= 1'b0;
            running_reg     <= WEIGHT_ONE;
            layer_reg       <= '0;
            for (int i = 0; i < wlbt_pkg::NUM_WEIGHT_REGS; i++) begin
                weight_reg[i] <= WEIGHT_ONE;
            end
            null_reg        <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == wlbt_pkg::REG_NULL_VALUE) begin
                    null_reg <= cfg_wdata;
                end else if (cfg_index < CFG_SEL_W'(wlbt_pkg::NUM_WEIGHT_REGS)) begin
                    weight_reg[cfg_index] <= cfg_wdata;
                end
            end

            // In the finish state a taken result is replaced by the new one below.
            if (m_tvalid_reg && m_tready && state_reg != ST_FINISH) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR: begin
                    if (clr_addr_reg == LAST_ADDR) begin
                        clr_addr_reg <= '0;
                        state_reg    <= ST_IDLE;
                    end else begin
                        clr_addr_reg <= clr_addr_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg       <= in_cmd;
                        addr_reg      <= in_addr;
                        in_range_reg  <= in_range;
                        src_reg       <= in_src;
                        src_null_reg  <= s_tuser[2];
                        lw_reg        <= layer_weight;
                        sum_reg       <= weight_sum;
                        res_value_reg <= '0;
                        res_flag_reg  <= 1'b0;
                        case (in_cmd)
                            wlbt_pkg::CMD_START: begin
                                layer_reg   <= '0;
                                running_reg <= weight_reg[0];
                                // Retiring the tag makes every stored sample blank;
                                // when the tag space runs out the store is swept.
                                if (epoch_reg == EPOCH_LAST) begin
                                    epoch_reg       <= EPOCH_FIRST;
                                    clear_after_reg <= 1'b1;
                                end else begin
                                    epoch_reg <= epoch_reg + 1'b1;
                                end
                                state_reg <= ST_FINISH;
                            end
                            wlbt_pkg::CMD_END_LAYER: begin
                                running_reg <= half_sum[WEIGHT_W-1:0];
                                if (layer_reg != LAYER_FULL) begin
                                    layer_reg <= layer_reg + 1'b1;
                                end
                                state_reg <= ST_FINISH;
                            end
                            default: begin
                                state_reg <= ST_EVAL;
                            end
                        endcase
                    end
                end
                ST_EVAL: begin
                    stored_reg <= entry_data;
                    if (!blend_active) begin
                        res_value_reg <= stored_or_null;
                        state_reg     <= ST_FINISH;
                    end else if (take_source) begin
                        res_value_reg <= src_reg;
                        res_flag_reg  <= entry_valid && (entry_data != null_reg);
                        state_reg     <= ST_FINISH;
                    end else begin
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    acc_reg   <= product;
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    // The quotient fits QUO_W bits, so the upper part of the
                    // numerator is already below the divisor.
                    rem_reg   <= numerator[NUM_W-1:QUO_W];
                    quo_reg   <= numerator[QUO_W-1:0];
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (!div_trial[SUM_W]) begin
                        rem_reg <= div_trial[SUM_W-1:0];
                    end else begin
                        rem_reg <= div_shift[SUM_W-1:0];
                    end
                    quo_reg <= {quo_reg[QUO_W-2:0], !div_trial[SUM_W]};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_STEP) begin
                        state_reg <= ST_WB;
                    end
                end
                ST_WB: begin
                    res_value_reg <= quo_reg;
                    state_reg     <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg    <= 1'b1;
                        m_value_reg     <= res_value_reg;
                        m_flag_reg      <= res_flag_reg;
                        m_layer_reg     <= layer_reg;
                        clear_after_reg <= 1'b0;
                        state_reg       <= clear_after_reg ? ST_CLEAR : ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_epoch_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        epoch_reg != '0)
        else $error("store tag reached the reserved blank value");

    a_div_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> rem_reg < sum_reg)
        else $error("divider remainder not below the weight sum");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("second item accepted while one is in progress");

    a_store_write_src: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> state_reg == ST_CLEAR || state_reg == ST_EVAL || state_reg == ST_WB)
        else $error("store written outside clear, blend or write-back");

    a_zero_sum_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINISH && res_flag_reg |-> sum_reg == '0)
        else $error("zero weight sum flag raised with a nonzero sum");
`endif

endmodule

// ===== tb/sv/weighted_layer_blend_tile_checker.sv =====
`timescale 1ns / 100ps

module weighted_layer_blend_tile_checker (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_tvalid,
    input  logic        s_tready,
    // sample_offset[13:0], source_sample[29:14], zero fill[31:30]
    input  logic [31:0] s_tdata,
    // command[1:0], source_is_null[2]
    input  logic [2:0]  s_tuser,

    input  logic        m_tvalid,
    input  logic        m_tready,
    // sample_value[15:0], current_layer[23:16]
    input  logic [23:0] m_tdata,
    // zero_weight_sum[0]
    input  logic [0:0]  m_tuser,

    output int          fail_count,
    output int          expected_left
);

    localparam int SAMPLE_W   = wlbt_pkg::SAMPLE_W;
    localparam int WEIGHT_W   = wlbt_pkg::WEIGHT_W;
    localparam int LAYER_W    = wlbt_pkg::LAYER_W;
    localparam int OFFSET_W   = wlbt_pkg::OFFSET_W;
    localparam int CMD_W      = wlbt_pkg::CMD_W;
    localparam int SUM_W      = wlbt_pkg::SUM_W;
    localparam int NUM_W      = wlbt_pkg::NUM_W;
    localparam int SEL_W      = wlbt_pkg::CFG_IDX_W;
    localparam int TILE_DEPTH = wlbt_pkg::TILE_SAMPLES_DEF;
    localparam int TOP_LAYER  = wlbt_pkg::WEIGHT_LAYERS_DEF - 1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_UNITY =
        WEIGHT_W'(1 << wlbt_pkg::WEIGHT_FRAC_BITS_DEF);
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                zero_sum;
        logic [LAYER_W-1:0]  layer;
    } tile_reply_t;

    logic [WEIGHT_W-1:0] layer_wt [wlbt_pkg::NUM_WEIGHT_REGS];
    logic [SAMPLE_W-1:0] blank_code;
    logic [SAMPLE_W-1:0] tile_mem [TILE_DEPTH];
    bit                  tile_vld [TILE_DEPTH];
    logic [WEIGHT_W-1:0] run_wt;
    logic [LAYER_W-1:0]  layer_num;
    tile_reply_t         replies_due [$];
    int                  errors = 0;

    initial begin
        fail_count    = 0;
        expected_left = 0;
    end

    function automatic logic [WEIGHT_W-1:0] weight_now();
        if (layer_num > LAYER_W'(TOP_LAYER)) begin
            return layer_wt[TOP_LAYER];
        end
        return layer_wt[layer_num[SEL_W-1:0]];
    endfunction

    function automatic logic [SAMPLE_W-1:0] sample_or_blank(
        input logic [OFFSET_W-1:0] addr
    );
        return tile_vld[addr] ? tile_mem[addr] : blank_code;
    endfunction

    // Applies one command to the tile model and returns the reply it produces.
    task automatic blend_into_tile(input wlbt_pkg::cmd_t cmd,
                                   input logic [OFFSET_W-1:0] addr,
                                   input logic [SAMPLE_W-1:0] src, input logic src_null,
                                   output tile_reply_t reply);
        logic [SUM_W-1:0] wsum;
        logic [SUM_W-1:0] run_ext;
        logic [NUM_W-1:0] stored_ext;
        logic [NUM_W-1:0] src_ext;
        logic [NUM_W-1:0] run_num;
        logic [NUM_W-1:0] wt_num;
        logic [NUM_W-1:0] numer;
        logic [NUM_W-1:0] quot;
        reply   = '0;
        run_ext = SUM_W'(run_wt);
        wsum    = run_ext + SUM_W'(weight_now());
        case (cmd)
            wlbt_pkg::CMD_START: begin
                foreach (tile_vld[i]) tile_vld[i] = 1'b0;
                layer_num = '0;
                run_wt    = layer_wt[0];
            end
            wlbt_pkg::CMD_BLEND: begin
                if (!src_null) begin
                    if (!tile_vld[addr] || tile_mem[addr] == blank_code) begin
                        tile_mem[addr] = src;
                    end else if (wsum == '0) begin
                        tile_mem[addr] = src;
                        reply.zero_sum = 1'b1;
                    end else begin
                        stored_ext     = NUM_W'(tile_mem[addr]);
                        src_ext        = NUM_W'(src);
                        run_num        = NUM_W'(run_wt);
                        wt_num         = NUM_W'(weight_now());
                        numer          = stored_ext * run_num + src_ext * wt_num;
                        quot           = numer / NUM_W'(wsum);
                        tile_mem[addr] = quot[SAMPLE_W-1:0];
                    end
                    tile_vld[addr] = 1'b1;
                end
                reply.sample = sample_or_blank(addr);
            end
            wlbt_pkg::CMD_END_LAYER: begin
                run_wt = wsum[SUM_W-1:1];
                if (layer_num != {LAYER_W{1'b1}}) begin
                    layer_num = layer_num + 1'b1;
                end
            end
            wlbt_pkg::CMD_READ: begin
                reply.sample = sample_or_blank(addr);
            end
            default: begin
                reply.sample = '0;
            end
        endcase
        reply.layer = layer_num;
    endtask

    always @(posedge aclk) begin : watch
        tile_reply_t want;
        tile_reply_t got;
        tile_reply_t next_reply;
        if (!aresetn) begin
            foreach (layer_wt[i]) layer_wt[i] = WEIGHT_UNITY;
            foreach (tile_vld[i]) tile_vld[i] = 1'b0;
            blank_code = '0;
            run_wt     = WEIGHT_UNITY;
            layer_num  = '0;
            replies_due.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index <= wlbt_pkg::REG_WEIGHT5) begin
                    layer_wt[cfg_index] = cfg_wdata;
                end else if (cfg_index == wlbt_pkg::REG_NULL_VALUE) begin
                    blank_code = cfg_wdata;
                end
            end
            if (m_tvalid && m_tready) begin
                got.sample   = m_tdata[SAMPLE_W-1:0];
                got.layer    = m_tdata[SAMPLE_W +: LAYER_W];
                got.zero_sum = m_tuser[0];
                if (replies_due.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_MAX) begin
                        $display("%0t: unexpected result: sample %h flag %0d layer %0d",
                                 $time, got.sample, got.zero_sum, got.layer);
                    end
                end else begin
                    want = replies_due.pop_front();
                    if (got.sample !== want.sample || got.zero_sum !== want.zero_sum ||
                        got.layer !== want.layer) begin
                        errors++;
                        if (errors <= REPORT_MAX) begin
                            $display("%0t: mismatch: expected sample %h flag %0d layer %0d,",
                                     $time, want.sample, want.zero_sum, want.layer);
                            $display("%0t:           got sample %h flag %0d layer %0d",
                                     $time, got.sample, got.zero_sum, got.layer);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                blend_into_tile(wlbt_pkg::cmd_t'(s_tuser[CMD_W-1:0]),
                                s_tdata[OFFSET_W-1:0],
                                s_tdata[OFFSET_W +: SAMPLE_W], s_tuser[CMD_W], next_reply);
                replies_due.insert(replies_due.size(), next_reply);
            end
        end
        expected_left <= replies_due.size();
        fail_count    <= errors;
    end

endmodule

// ===== tb/sv/tb_weighted_layer_blend_tile_top.sv =====
`timescale 1ns / 100ps

module tb_weighted_layer_blend_tile_top;

    localparam int OFFSET_W        = wlbt_pkg::OFFSET_W;
    localparam int SAMPLE_W        = wlbt_pkg::SAMPLE_W;
    localparam int WEIGHT_W        = wlbt_pkg::WEIGHT_W;
    localparam int CFG_IDX_W       = wlbt_pkg::CFG_IDX_W;
    localparam int NUM_WEIGHT_REGS = wlbt_pkg::NUM_WEIGHT_REGS;
    localparam int TILE_SAMPLES    = wlbt_pkg::TILE_SAMPLES_DEF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE =
        WEIGHT_W'(1 << wlbt_pkg::WEIGHT_FRAC_BITS_DEF);

    // The slowest legal run stays well under the cycle limit: about 1600 transfers, each
    // with random idle gaps on each side, and a few store clearing passes.
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int FIRST_TILES  = 500;
    localparam int ITEM_TARGET  = 1325;
    localparam int SAT_STEPS    = 265;
    localparam int STORM_STARTS = 260;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    int fail_count;
    int expected_left;
    int cycle_count = 0;
    int items_sent  = 0;
    bit send_gaps   = 1'b0;
    bit take_gaps   = 1'b0;

    logic [WEIGHT_W-1:0] next_wt [NUM_WEIGHT_REGS];
    logic [SAMPLE_W-1:0] next_blank = '0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    weighted_layer_blend_tile_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    weighted_layer_blend_tile_checker scoreboard (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[weighted_layer_blend_tile_top] ERROR");
            $finish;
        end
    end

    // Result side: if take_gaps is set, stall a random number of cycles per transfer.
    initial begin : result_sink
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = take_gaps ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_item(input wlbt_pkg::cmd_t cmd, input logic [OFFSET_W-1:0] offs,
                             input logic [SAMPLE_W-1:0] src, input logic src_null);
        int gap;
        gap = send_gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, src, offs};
        s_tuser  <= {src_null, cmd};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Offset, source and null flag are random; start and end-of-layer ignore all three.
    task automatic send_random(input wlbt_pkg::cmd_t cmd);
        send_item(cmd, OFFSET_W'($urandom), SAMPLE_W'($urandom), 1'($urandom));
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // The spare index is written last so that a decode that aliases it onto a real
    // register would leave a wrong value behind.
    task automatic write_settings(input bit with_spare);
        for (int i = 0; i < NUM_WEIGHT_REGS; i++) begin
            put_reg(wlbt_pkg::reg_idx_t'(i), next_wt[i]);
        end
        put_reg(wlbt_pkg::REG_NULL_VALUE, next_blank);
        if (with_spare) begin
            put_reg(REG_SPARE, ~next_blank);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Every result has to be back before registers change; the extra cycles cover
    // the longest mean computation.
    task automatic drain_and_pause();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_left != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        logic [WEIGHT_W-1:0] w;
        w = WEIGHT_W'($urandom);
        case ($urandom_range(0, 5))
            0: w = '0;
            1: w = '1;
            2: w = WEIGHT_ONE;
            default: ;
        endcase
        return w;
    endfunction

    // Sources equal to the null value exercise the blank-overwrite path.
    function automatic logic [SAMPLE_W-1:0] pick_source();
        logic [SAMPLE_W-1:0] s;
        s = SAMPLE_W'($urandom);
        case ($urandom_range(0, 9))
            0: s = next_blank;
            1: s = '0;
            2: s = '1;
            default: ;
        endcase
        return s;
    endfunction

    task automatic new_phase();
        int blank_pick;
        drain_and_pause();
        foreach (next_wt[i]) next_wt[i] = pick_weight();
        blank_pick = $urandom_range(0, 3);
        next_blank = (blank_pick == 0) ? '0 : (blank_pick == 1) ? '1 : SAMPLE_W'($urandom);
        write_settings($urandom_range(0, 3) == 0);
        send_gaps = ($urandom_range(0, 1) == 1);
        take_gaps = ($urandom_range(0, 1) == 1);
    endtask

    task automatic run_tile();
        int n_layers;
        int per_layer;
        int base;
        int span;
        int pick;
        logic [OFFSET_W-1:0] offs;
        n_layers = $urandom_range(1, 8);
        span     = $urandom_range(4, 32);
        base     = $urandom_range(0, TILE_SAMPLES - span);
        // Now and then the start is left out, so blending continues on the old tile.
        if ($urandom_range(0, 7) != 0) begin
            send_random(wlbt_pkg::CMD_START);
        end
        for (int l = 0; l < n_layers; l++) begin
            per_layer = $urandom_range(2, 12);
            for (int k = 0; k < per_layer; k++) begin
                offs = OFFSET_W'(base + $urandom_range(0, span - 1));
                pick = $urandom_range(0, 19);
                if (pick < 13) begin
                    send_item(wlbt_pkg::CMD_BLEND, offs, pick_source(), 1'b0);
                end else if (pick < 15) begin
                    send_item(wlbt_pkg::CMD_BLEND, offs, pick_source(), 1'b1);
                end else if (pick < 18) begin
                    send_item(wlbt_pkg::CMD_READ, offs, SAMPLE_W'($urandom), 1'($urandom));
                end else begin
                    send_random(wlbt_pkg::cmd_t'($urandom_range(0, 3)));
                end
            end
            send_random(wlbt_pkg::CMD_END_LAYER);
        end
    endtask

    initial begin : stimulus
        int base;
        logic [OFFSET_W-1:0] offs;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset weights of 1.0 and a null value of zero.
        send_item(wlbt_pkg::CMD_READ,      14'h0000, 16'h0000, 1'b0);
        send_item(wlbt_pkg::CMD_BLEND,     14'h0000, 16'hFFFF, 1'b0);
        send_item(wlbt_pkg::CMD_BLEND,     14'h0000, 16'h0000, 1'b0);
        send_item(wlbt_pkg::CMD_BLEND,     14'h3FFF, 16'hFFFF, 1'b1);
        send_item(wlbt_pkg::CMD_BLEND,     14'h3FFF, 16'hABCD, 1'b0);
        send_item(wlbt_pkg::CMD_READ,      14'h3FFF, 16'hFFFF, 1'b1);
        send_item(wlbt_pkg::CMD_END_LAYER, 14'h3FFF, 16'hFFFF, 1'b1);
        send_item(wlbt_pkg::CMD_BLEND,     14'h0000, 16'h1234, 1'b1);
        send_item(wlbt_pkg::CMD_START,     14'h2AAA, 16'h5555, 1'b0);
        send_item(wlbt_pkg::CMD_READ,      14'h0000, 16'h0000, 1'b0);

        // All weights zero: a blend onto a stored sample meets a zero weight sum.
        drain_and_pause();
        foreach (next_wt[i]) next_wt[i] = '0;
        next_blank = 16'h5A5A;
        write_settings(1'b1);
        send_item(wlbt_pkg::CMD_START,     14'h1555, 16'hAAAA, 1'b1);
        send_item(wlbt_pkg::CMD_BLEND,     14'h0005, 16'h5A5A, 1'b0);
        send_item(wlbt_pkg::CMD_BLEND,     14'h0005, 16'h0001, 1'b0);
        send_item(wlbt_pkg::CMD_BLEND,     14'h0005, 16'h8000, 1'b0);
        send_item(wlbt_pkg::CMD_END_LAYER, 14'h0005, 16'h0000, 1'b0);
        send_item(wlbt_pkg::CMD_READ,      14'h0005, 16'h0000, 1'b0);

        // Largest weights with the null value at full scale.
        drain_and_pause();
        foreach (next_wt[i]) next_wt[i] = '1;
        next_blank = '1;
        write_settings(1'b1);
        send_item(wlbt_pkg::CMD_START,     14'h0000, 16'h0000, 1'b0);
        send_item(wlbt_pkg::CMD_BLEND,     14'h2AAA, 16'h0000, 1'b0);
        send_item(wlbt_pkg::CMD_BLEND,     14'h2AAA, 16'hFFFE, 1'b0);
        send_item(wlbt_pkg::CMD_END_LAYER, 14'h0000, 16'h0000, 1'b0);
        send_item(wlbt_pkg::CMD_BLEND,     14'h2AAA, 16'h1555, 1'b0);
        send_item(wlbt_pkg::CMD_READ,      14'h1555, 16'h0000, 1'b0);
        send_item(wlbt_pkg::CMD_BLEND,     14'h1555, 16'hFFFF, 1'b0);

        while (items_sent < FIRST_TILES) begin
            new_phase();
            repeat ($urandom_range(1, 3)) run_tile();
        end

        // Run the layer counter into saturation, past the end of the weight table.
        new_phase();
        base = $urandom_range(0, TILE_SAMPLES - 8);
        send_random(wlbt_pkg::CMD_START);
        for (int k = 0; k < SAT_STEPS; k++) begin
            offs = OFFSET_W'(base + $urandom_range(0, 7));
            if (k % 16 == 5) begin
                send_item(wlbt_pkg::CMD_BLEND, offs, pick_source(), 1'b0);
            end else if (k % 32 == 11) begin
                send_item(wlbt_pkg::CMD_READ, offs, SAMPLE_W'($urandom), 1'($urandom));
            end
            send_random(wlbt_pkg::CMD_END_LAYER);
        end
        repeat (6) begin
            offs = OFFSET_W'(base + $urandom_range(0, 7));
            send_item(wlbt_pkg::CMD_BLEND, offs, pick_source(), 1'b0);
        end

        // Many starts in a row wrap the tile generation count of the store.
        new_phase();
        base = $urandom_range(0, TILE_SAMPLES - 4);
        for (int k = 0; k < STORM_STARTS; k++) begin
            send_random(wlbt_pkg::CMD_START);
            offs = OFFSET_W'(base + $urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: send_item(wlbt_pkg::CMD_BLEND, offs, pick_source(), 1'b0);
                1: send_item(wlbt_pkg::CMD_READ, offs, SAMPLE_W'($urandom), 1'($urandom));
                default: ;
            endcase
        end

        while (items_sent < ITEM_TARGET) begin
            new_phase();
            repeat ($urandom_range(1, 3)) run_tile();
        end

        drain_and_pause();
        if (fail_count == 0 && expected_left == 0) begin
            $display("[weighted_layer_blend_tile_top] OK");
        end else begin
            $display("[weighted_layer_blend_tile_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/wlbt_pkg.sv
design/wlbt_ram.sv
design/weighted_layer_blend_tile_top.sv
tb/sv/weighted_layer_blend_tile_checker.sv
tb/sv/tb_weighted_layer_blend_tile_top.sv
